FILE: rtl/wmst_pkg.sv
// ---------------------------------------------------------------------------
// wmst_pkg: shared types and constants
// Widths, register indexes, sequencer states and shared-unit operations for
// the windowed mean, deviation and threshold core.
// ---------------------------------------------------------------------------
package wmst_pkg;

   // Sizes of the sample window and the fields.
   localparam int WINDOW_MAX   = 64;
   localparam int SAMPLE_BITS  = 16;
   localparam int RING_AW      = $clog2(WINDOW_MAX);
   localparam int WIN_W        = 7;
   localparam int SUM_W        = 22;
   localparam int SQSUM_W      = 38;
   localparam int MEAN_W       = 16;
   localparam int STD_W        = 15;
   localparam int PLAIN_W      = 24;
   localparam int TMIN_W       = 25;
   localparam int TMAX_W       = 32;
   localparam int RATIO_W      = 16;

   // Shared unit widths.
   localparam int OPA_W        = 25;
   localparam int OPB_W        = 45;
   localparam int MUL_B_W      = 22;
   localparam int PROD_W       = OPA_W + MUL_B_W;
   localparam int DVS_W        = 13;
   localparam int RAD_W        = 32;
   localparam int ROOT_W       = 16;
   localparam int STEP_W       = 6;

   // Step counts of the iterative operations.
   localparam int MEAN_STEPS   = SUM_W;
   localparam int VAR_STEPS    = OPB_W;
   localparam int SQRT_STEPS   = ROOT_W;

   // Register reset values.
   localparam logic [WIN_W-1:0]   WINDOW_RESET  = 7'd16;
   localparam logic [RATIO_W-1:0] RLOW_RESET    = 16'd256;
   localparam logic [RATIO_W-1:0] RHIGH_RESET   = 16'd512;
   localparam logic [RATIO_W-1:0] PENALTY_RESET = 16'd256;

   // Configuration register indexes.
   localparam int CSR_IDX_W = 8;
   localparam logic [CSR_IDX_W-1:0] REG_WINDOW_SIZE    = 8'd0;
   localparam logic [CSR_IDX_W-1:0] REG_RATIO_LOW      = 8'd1;
   localparam logic [CSR_IDX_W-1:0] REG_RATIO_HIGH     = 8'd2;
   localparam logic [CSR_IDX_W-1:0] REG_SPREAD_PENALTY = 8'd3;

   // Shared unit operations.
   typedef enum logic [2:0] {
      ALU_IDLE,
      ALU_MUL,
      ALU_DIV_LOAD,
      ALU_DIV_STEP,
      ALU_SQRT_LOAD,
      ALU_SQRT_STEP
   } alu_op_type;

   // Command from the sequencer to the shared unit.
   typedef struct packed {
      alu_op_type             op;
      logic [OPA_W-1:0]       opa;
      logic [OPB_W-1:0]       opb;
   } alu_ctl_type;

   // Sequencer states.
   typedef enum logic [4:0] {
      ST_IDLE,
      ST_READ,
      ST_SQ_OLD,
      ST_SQ_NEW,
      ST_SS,
      ST_NQ_LO,
      ST_NQ_HI,
      ST_NN,
      ST_DIV_MEAN,
      ST_MEAN_DONE,
      ST_DIV_VAR,
      ST_VAR_DONE,
      ST_SQRT,
      ST_SD_DONE,
      ST_PLAIN,
      ST_TMIN,
      ST_TMAX,
      ST_OUT
   } state_type;

endpackage

FILE: rtl/wmst_ram.sv
// ---------------------------------------------------------------------------
// wmst_ram: generic single-port-write RAM
// One write port and one read port, read data registered.
// ---------------------------------------------------------------------------
module wmst_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port and registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/wmst_alu.sv
// ---------------------------------------------------------------------------
// wmst_alu: shared arithmetic unit
// A registered multiplier, one restoring divide step and one square root
// step, driven one operation a cycle by the sequencer.
// ---------------------------------------------------------------------------
module wmst_alu
   import wmst_pkg::*;
(
   input  logic                clock,
   input  alu_ctl_type         ctl,
   output logic [PROD_W-1:0]   prod,
   output logic [OPB_W-1:0]    quo,
   output logic [ROOT_W-1:0]   root
);

   logic [PROD_W-1:0]  prod_ff;
   logic [OPB_W-1:0]   dq_ff;
   logic [DVS_W-1:0]   rem_ff;
   logic [DVS_W-1:0]   dvs_ff;
   logic [RAD_W-1:0]   rad_ff;
   logic [ROOT_W+2:0]  srem_ff;
   logic [ROOT_W-1:0]  root_ff;

   logic [DVS_W:0]     div_trial;
   logic               q_bit;
   logic [DVS_W-1:0]   rem_in;
   logic [ROOT_W+2:0]  sq_trial;
   logic [ROOT_W+2:0]  sq_cmp;
   logic               r_bit;
   logic [ROOT_W+2:0]  srem_in;

   // One restoring division step: bring down the next dividend bit.
   always_comb begin
      div_trial = {rem_ff, dq_ff[OPB_W-1]};
      q_bit     = div_trial >= {1'b0, dvs_ff};
      rem_in    = q_bit ? DVS_W'(div_trial - {1'b0, dvs_ff}) : div_trial[DVS_W-1:0];
   end

   // One square root step: bring down the next pair of radicand bits.
   always_comb begin
      sq_trial = {srem_ff[ROOT_W:0], rad_ff[RAD_W-1:RAD_W-2]};
      sq_cmp   = {1'b0, root_ff, 2'b01};
      r_bit    = sq_trial >= sq_cmp;
      srem_in  = r_bit ? (sq_trial - sq_cmp) : sq_trial;
   end

   // Operation registers.
   always_ff @(posedge clock) begin
      case (ctl.op)
         ALU_MUL: begin
            prod_ff <= PROD_W'(ctl.opa) * PROD_W'(ctl.opb[MUL_B_W-1:0]);
         end
         ALU_DIV_LOAD: begin
            dq_ff  <= ctl.opb;
            rem_ff <= '0;
            dvs_ff <= ctl.opa[DVS_W-1:0];
         end
         ALU_DIV_STEP: begin
            dq_ff  <= {dq_ff[OPB_W-2:0], q_bit};
            rem_ff <= rem_in;
         end
         ALU_SQRT_LOAD: begin
            rad_ff  <= ctl.opb[RAD_W-1:0];
            srem_ff <= '0;
            root_ff <= '0;
         end
         ALU_SQRT_STEP: begin
            rad_ff  <= {rad_ff[RAD_W-3:0], 2'b00};
            srem_ff <= srem_in;
            root_ff <= {root_ff[ROOT_W-2:0], r_bit};
         end
         default: begin
         end
      endcase
   end

   assign prod = prod_ff;
   assign quo  = dq_ff;
   assign root = root_ff;

endmodule

FILE: rtl/windowed_mean_stddev_threshold_core.sv
// ---------------------------------------------------------------------------
// windowed_mean_stddev_threshold_core: sliding window statistics
// Keeps the most recent samples in a ring with running sums, and for each
// item gives the mean, population deviation and three thresholds.
// ---------------------------------------------------------------------------
// An accepted item passes through six setup products, the 22-step mean
// divide, the 45-step variance divide, the 16-step root, the threshold
// states and the output load.
// One item is in work at a time, and the next item is taken while the
// previous result waits on the output.
// Reset clears the window, pointers, sums and the output valid, and loads
// the register defaults; the sample ring is not cleared.
module windowed_mean_stddev_threshold_core
   import wmst_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   // Input items.
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [15:0]           req_tdata,   // [15:0] strength_sample
   // Result items.
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [111:0]          rsp_tdata,   // [15:0] mean, [30:16] std_dev,
                                              // [54:31] threshold_plain,
                                              // [79:55] threshold_min,
                                              // [111:80] threshold_max
   // Configuration writes.
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [15:0]           csr_data
);

   state_type              state_ff, state_in;
   logic [STEP_W-1:0]      step_ff, step_in;

   logic [WIN_W-1:0]       window_ff;
   logic [RATIO_W-1:0]     rlow_ff;
   logic [RATIO_W-1:0]     rhigh_ff;
   logic [RATIO_W-1:0]     penalty_ff;

   logic [RING_AW-1:0]     wp_ff;
   logic [WIN_W-1:0]       fill_ff;
   logic [SUM_W-1:0]       sum_ff;
   logic [SQSUM_W-1:0]     sq_ff;

   logic [SAMPLE_BITS-1:0] x_ff;
   logic [SAMPLE_BITS-1:0] old_val;
   logic [OPB_W-1:0]       ss_ff;
   logic [OPB_W-1:0]       nq_ff;
   logic [OPB_W-1:0]       diff_ff;
   logic [DVS_W-1:0]       nn_ff;
   logic [MEAN_W-1:0]      mean_ff;
   logic [STD_W-1:0]       sd_ff;
   logic [PLAIN_W-1:0]     plain_ff;
   logic [TMIN_W-1:0]      tmin_ff;
   logic [TMAX_W-1:0]      tmax_ff;

   logic                   rsp_valid_ff;
   logic [111:0]           rsp_data_ff;

   logic [WIN_W-1:0]       n_eff;
   logic                   full;
   logic                   req_fire;
   logic                   csr_fire;
   logic                   out_load;
   logic [SAMPLE_BITS-1:0] ring_rdata;
   alu_ctl_type            alu_ctl;
   logic [PROD_W-1:0]      prod;
   logic [OPB_W-1:0]       quo;
   logic [ROOT_W-1:0]      root;

   // Effective window: zero acts as one, large values clamp to the maximum.
   always_comb begin
      if (window_ff == '0) begin
         n_eff = WIN_W'(1);
      end else if (window_ff > WIN_W'(WINDOW_MAX)) begin
         n_eff = WIN_W'(WINDOW_MAX);
      end else begin
         n_eff = window_ff;
      end
   end

   assign full       = fill_ff >= n_eff;
   assign req_tready = state_ff == ST_IDLE;
   assign req_fire   = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;
   assign csr_fire   = csr_valid && csr_ready;
   assign out_load   = (state_ff == ST_OUT) && (!rsp_valid_ff || rsp_tready);
   assign old_val    = full ? ring_rdata : '0;

   // Sample ring.
   wmst_ram #(
      .WIDTH (SAMPLE_BITS),
      .DEPTH (WINDOW_MAX)
   ) u_ring (
      .clock   (clock),
      .wr_en   (state_ff == ST_READ),
      .wr_addr (wp_ff),
      .wr_data (x_ff),
      .rd_en   (req_fire),
      .rd_addr (wp_ff),
      .rd_data (ring_rdata)
   );

   // Shared arithmetic unit.
   wmst_alu u_alu (
      .clock (clock),
      .ctl   (alu_ctl),
      .prod  (prod),
      .quo   (quo),
      .root  (root)
   );

   // Sequencer state register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
      end
   end

   // Next state and commands to the shared unit.
   always_comb begin
      state_in    = state_ff;
      step_in     = step_ff;
      alu_ctl.op  = ALU_IDLE;
      alu_ctl.opa = '0;
      alu_ctl.opb = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            alu_ctl.op  = ALU_MUL;
            alu_ctl.opa = OPA_W'(old_val);
            alu_ctl.opb = OPB_W'(old_val);
            state_in    = ST_SQ_OLD;
         end
         ST_SQ_OLD: begin
            alu_ctl.op  = ALU_MUL;
            alu_ctl.opa = OPA_W'(x_ff);
            alu_ctl.opb = OPB_W'(x_ff);
            state_in    = ST_SQ_NEW;
         end
         ST_SQ_NEW: begin
            alu_ctl.op  = ALU_MUL;
            alu_ctl.opa = OPA_W'(sum_ff);
            alu_ctl.opb = OPB_W'(sum_ff);
            state_in    = ST_SS;
         end
         ST_SS: begin
            alu_ctl.op  = ALU_MUL;
            alu_ctl.opa = OPA_W'(fill_ff);
            alu_ctl.opb = OPB_W'(sq_ff[18:0]);
            state_in    = ST_NQ_LO;
         end
         ST_NQ_LO: begin
            alu_ctl.op  = ALU_MUL;
            alu_ctl.opa = OPA_W'(fill_ff);
            alu_ctl.opb = OPB_W'(sq_ff[SQSUM_W-1:19]);
            state_in    = ST_NQ_HI;
         end
         ST_NQ_HI: begin
            alu_ctl.op  = ALU_MUL;
            alu_ctl.opa = OPA_W'(fill_ff);
            alu_ctl.opb = OPB_W'(fill_ff);
            state_in    = ST_NN;
         end
         ST_NN: begin
            // Mean first: the sum is left-aligned in the dividend.
            alu_ctl.op  = ALU_DIV_LOAD;
            alu_ctl.opa = OPA_W'(fill_ff);
            alu_ctl.opb = {sum_ff, (OPB_W - SUM_W)'(0)};
            step_in     = STEP_W'(MEAN_STEPS - 1);
            state_in    = ST_DIV_MEAN;
         end
         ST_DIV_MEAN: begin
            alu_ctl.op = ALU_DIV_STEP;
            step_in    = step_ff - 1'b1;
            if (step_ff == '0) begin
               state_in = ST_MEAN_DONE;
            end
         end
         ST_MEAN_DONE: begin
            alu_ctl.op  = ALU_DIV_LOAD;
            alu_ctl.opa = OPA_W'(nn_ff);
            alu_ctl.opb = diff_ff;
            step_in     = STEP_W'(VAR_STEPS - 1);
            state_in    = ST_DIV_VAR;
         end
         ST_DIV_VAR: begin
            alu_ctl.op = ALU_DIV_STEP;
            step_in    = step_ff - 1'b1;
            if (step_ff == '0) begin
               state_in = ST_VAR_DONE;
            end
         end
         ST_VAR_DONE: begin
            alu_ctl.op  = ALU_SQRT_LOAD;
            alu_ctl.opb = OPB_W'(quo[RAD_W-1:0]);
            step_in     = STEP_W'(SQRT_STEPS - 1);
            state_in    = ST_SQRT;
         end
         ST_SQRT: begin
            alu_ctl.op = ALU_SQRT_STEP;
            step_in    = step_ff - 1'b1;
            if (step_ff == '0) begin
               state_in = ST_SD_DONE;
            end
         end
         ST_SD_DONE: begin
            alu_ctl.op  = ALU_MUL;
            alu_ctl.opa = OPA_W'(mean_ff);
            alu_ctl.opb = OPB_W'(rlow_ff);
            state_in    = ST_PLAIN;
         end
         ST_PLAIN: begin
            alu_ctl.op  = ALU_MUL;
            alu_ctl.opa = OPA_W'(sd_ff);
            alu_ctl.opb = OPB_W'(penalty_ff);
            state_in    = ST_TMIN;
         end
         ST_TMIN: begin
            state_in = ST_TMAX;
         end
         ST_TMAX: begin
            state_in = ST_OUT;
         end
         ST_OUT: begin
            if (out_load) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      // The last product rebuilds the lower threshold from plain_ff and prod.
      if (state_ff == ST_TMIN) begin
         alu_ctl.op  = ALU_MUL;
         alu_ctl.opa = OPA_W'(plain_ff) + OPA_W'(prod[30:8]);
         alu_ctl.opb = OPB_W'(rhigh_ff);
      end
   end

   // Configuration registers and window state.
   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff  <= WINDOW_RESET;
         rlow_ff    <= RLOW_RESET;
         rhigh_ff   <= RHIGH_RESET;
         penalty_ff <= PENALTY_RESET;
         wp_ff      <= '0;
         fill_ff    <= '0;
         sum_ff     <= '0;
         sq_ff      <= '0;
      end else if (csr_fire) begin
         case (csr_index)
            REG_WINDOW_SIZE: begin
               window_ff <= csr_data[WIN_W-1:0];
               wp_ff     <= '0;
               fill_ff   <= '0;
               sum_ff    <= '0;
               sq_ff     <= '0;
            end
            REG_RATIO_LOW:      rlow_ff    <= csr_data;
            REG_RATIO_HIGH:     rhigh_ff   <= csr_data;
            REG_SPREAD_PENALTY: penalty_ff <= csr_data;
            default: begin
            end
         endcase
      end else begin
         case (state_ff)
            ST_READ: begin
               // Drop the oldest sample when full, then take the new one in.
               sum_ff  <= sum_ff - SUM_W'(old_val) + SUM_W'(x_ff);
               fill_ff <= full ? n_eff : fill_ff + 1'b1;
               if ((WIN_W'(wp_ff) + 1'b1) >= n_eff) begin
                  wp_ff <= '0;
               end else begin
                  wp_ff <= wp_ff + 1'b1;
               end
            end
            ST_SQ_OLD: sq_ff <= sq_ff - SQSUM_W'(prod[31:0]);
            ST_SQ_NEW: sq_ff <= sq_ff + SQSUM_W'(prod[31:0]);
            default: begin
            end
         endcase
      end
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      if (req_fire) begin
         x_ff <= req_tdata;
      end
      case (state_ff)
         ST_SS:        ss_ff    <= OPB_W'(prod[43:0]);
         ST_NQ_LO:     nq_ff    <= OPB_W'(prod[25:0]);
         ST_NQ_HI:     nq_ff    <= nq_ff + {prod[25:0], 19'b0};
         ST_NN: begin
            nn_ff   <= prod[DVS_W-1:0];
            diff_ff <= nq_ff - ss_ff;
         end
         ST_MEAN_DONE: mean_ff  <= quo[MEAN_W-1:0];
         ST_SD_DONE:   sd_ff    <= root[STD_W-1:0];
         ST_PLAIN:     plain_ff <= prod[31:8];
         ST_TMIN:      tmin_ff  <= TMIN_W'(plain_ff) + TMIN_W'(prod[30:8]);
         ST_TMAX: begin
            // Saturate the upper threshold at 32 bits.
            if (|prod[PROD_W-1:40]) begin
               tmax_ff <= '1;
            end else begin
               tmax_ff <= prod[39:8];
            end
         end
         default: begin
         end
      endcase
   end

   // Output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (out_load) begin
         rsp_data_ff <= {tmax_ff, tmin_ff, plain_ff, sd_ff, mean_ff};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // The window never holds more samples than it may.
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= WIN_W'(WINDOW_MAX))
      else $error("fill count above window maximum");

   // The write pointer stays inside the effective window.
   a_wp_bound: assert property (@(posedge clock) disable iff (reset)
      WIN_W'(wp_ff) < n_eff)
      else $error("write pointer outside window");

   // An accepted item starts the ring read state.
   a_start: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> state_ff == ST_READ)
      else $error("accepted item did not start the sequence");

   // A new result appears only as the sequence returns to idle.
   a_result: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> state_ff == ST_IDLE)
      else $error("result raised outside sequence end");

endmodule

FILE: tb/tb_top.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_top: windowed mean, deviation and threshold core testbench
// Feeds sample items and configuration writes into the core, predicts the
// mean, deviation and thresholds of each item in a window model of its own,
// and checks every result item against the oldest prediction in order.
// ---------------------------------------------------------------------------
module tb_top;
   import wmst_pkg::*;

   localparam int NO_ACCEPT_LIMIT = 20000;
   localparam int SETTLE_CYCLES   = 300;

   // One predicted result item.
   typedef struct {
      logic [MEAN_W-1:0]  mean;
      logic [STD_W-1:0]   std_dev;
      logic [PLAIN_W-1:0] plain;
      logic [TMIN_W-1:0]  tmin;
      logic [TMAX_W-1:0]  tmax;
   } stats_type;

   // Window model and store of pending statistics.
   class window_stats_board;
      logic [SAMPLE_BITS-1:0] ring [WINDOW_MAX];
      int unsigned            wr_ptr;
      int unsigned            fill;
      longint unsigned        sum;
      longint unsigned        sq_sum;
      logic [WIN_W-1:0]       win_size;
      logic [RATIO_W-1:0]     ratio_lo;
      logic [RATIO_W-1:0]     ratio_hi;
      logic [RATIO_W-1:0]     penalty;
      stats_type              pending_stats [$];
      int                     errors;

      function new();
         wr_ptr   = 0;
         fill     = 0;
         sum      = 0;
         sq_sum   = 0;
         win_size = WINDOW_RESET;
         ratio_lo = RLOW_RESET;
         ratio_hi = RHIGH_RESET;
         penalty  = PENALTY_RESET;
         errors   = 0;
      endfunction

      task report(string what, longint unsigned got, longint unsigned want);
         errors++;
         $display("Mismatch at %0t: %s got %0d, expected %0d", $time, what, got, want);
      endtask

      // A window size write also empties the window.
      function void note_write(logic [CSR_IDX_W-1:0] idx, logic [15:0] value);
         case (idx)
            REG_WINDOW_SIZE: begin
               win_size = value[WIN_W-1:0];
               wr_ptr   = 0;
               fill     = 0;
               sum      = 0;
               sq_sum   = 0;
            end
            REG_RATIO_LOW:      ratio_lo = value;
            REG_RATIO_HIGH:     ratio_hi = value;
            REG_SPREAD_PENALTY: penalty  = value;
            default: ;
         endcase
      endfunction

      function longint unsigned root_floor(longint unsigned v);
         longint unsigned res, bitv;
         res  = 0;
         bitv = 64'd1 << 62;
         while (bitv > v) bitv >>= 2;
         while (bitv != 0) begin
            if (v >= res + bitv) begin
               v  -= res + bitv;
               res = (res >> 1) + bitv;
            end else begin
               res >>= 1;
            end
            bitv >>= 2;
         end
         return res;
      endfunction

      function longint unsigned clip(longint unsigned v, longint unsigned lim);
         return (v > lim) ? lim : v;
      endfunction

      // Advance the window by one sample and queue its statistics.
      function void note_sample(logic [SAMPLE_BITS-1:0] x);
         int unsigned     n_eff, slot;
         longint unsigned n, variance, m, sd, pl, tmn, tmx;
         stats_type       st;
         n_eff = (win_size == 0) ? 1 : (win_size > WINDOW_MAX) ? WINDOW_MAX : win_size;
         slot  = wr_ptr % n_eff;
         if (fill >= n_eff) begin
            sum    -= ring[slot];
            sq_sum -= longint'(ring[slot]) * ring[slot];
            fill    = n_eff;
         end else begin
            fill++;
         end
         ring[slot] = x;
         sum    += x;
         sq_sum += longint'(x) * x;
         wr_ptr  = (slot + 1 >= n_eff) ? 0 : slot + 1;
         n        = fill;
         variance = (n * sq_sum - sum * sum) / (n * n);
         m   = clip(sum / n, 64'hFFFF);
         sd  = clip(root_floor(variance), 64'h7FFF);
         pl  = clip((ratio_lo * m) >> 8, 64'hFF_FFFF);
         tmn = clip(pl + ((penalty * sd) >> 8), 64'h1FF_FFFF);
         tmx = clip((ratio_hi * tmn) >> 8, 64'hFFFF_FFFF);
         st.mean    = MEAN_W'(m);
         st.std_dev = STD_W'(sd);
         st.plain   = PLAIN_W'(pl);
         st.tmin    = TMIN_W'(tmn);
         st.tmax    = TMAX_W'(tmx);
         pending_stats = {pending_stats, st};
      endfunction

      task check_result(logic [111:0] d);
         stats_type st;
         if (pending_stats.size() == 0) begin
            report("unexpected result item", d[15:0], 0);
         end else begin
            st = pending_stats.pop_front();
            if (d[15:0] !== st.mean) report("mean", d[15:0], st.mean);
            if (d[30:16] !== st.std_dev) report("std_dev", d[30:16], st.std_dev);
            if (d[54:31] !== st.plain) report("threshold_plain", d[54:31], st.plain);
            if (d[79:55] !== st.tmin) report("threshold_min", d[79:55], st.tmin);
            if (d[111:80] !== st.tmax) report("threshold_max", d[111:80], st.tmax);
         end
      endtask
   endclass

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_tvalid = 1'b0;
   logic                 req_tready;
   logic [15:0]          req_tdata = '0;
   logic                 rsp_tvalid;
   logic                 rsp_tready = 1'b0;
   logic [111:0]         rsp_tdata;
   logic                 csr_valid = 1'b0;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [15:0]          csr_data = '0;

   window_stats_board board = new();
   int                send_idle_pct = 0;
   int                stall_pct = 0;
   int                quiet_cycles = 0;

   windowed_mean_stddev_threshold_core dut (.*);

   always #10 clock = ~clock;

   // Receiver back-pressure.
   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(99) >= stall_pct);
   end

   // Result checking and the no-progress watchdog.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) board.check_result(rsp_tdata);
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready) || reset) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= NO_ACCEPT_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Offer one sample; valid stays high into the next item unless idling.
   task send_sample(logic [15:0] x);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= x;
      do @(posedge clock); while (!req_tready);
      board.note_sample(x);
   endtask

   // Let all pending predictions be checked, then let the core settle.
   task drain;
      req_tvalid <= 1'b0;
      while (board.pending_stats.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task write_reg(logic [CSR_IDX_W-1:0] idx, logic [15:0] value);
      drain();
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      board.note_write(idx, value);
      csr_valid <= 1'b0;
   endtask

   // Samples are mostly uniform, with bursts of extremes and narrow spreads.
   function logic [15:0] pick_sample(int style);
      case (style)
         0: return $urandom_range(1) ? 16'hFFFF : 16'h0000;
         1: return 16'h8000 + 16'($urandom_range(15));
         default: return 16'($urandom);
      endcase
   endfunction

   task random_phase(int items);
      int style;
      logic [15:0] w;
      case ($urandom_range(5))
         0: w = 16'd1;
         1: w = 16'd64;
         2: w = 16'd0;
         3: w = 16'hFF80 | 16'($urandom_range(127));
         default: w = 16'($urandom_range(2, 63));
      endcase
      write_reg(REG_WINDOW_SIZE, w);
      write_reg(REG_RATIO_LOW, 16'($urandom));
      write_reg(REG_RATIO_HIGH, 16'($urandom));
      write_reg(REG_SPREAD_PENALTY, 16'($urandom));
      if ($urandom_range(3) == 0) begin
         write_reg(CSR_IDX_W'($urandom_range(4, 255)), 16'($urandom));
      end
      style = $urandom_range(3);
      for (int i = 0; i < items; i++) send_sample(pick_sample(style));
   endtask

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: defaults, extremes, window limits and the full window drop.
      send_sample(16'h0000);
      send_sample(16'hFFFF);
      send_sample(16'hFFFF);
      send_sample(16'h0001);
      write_reg(REG_RATIO_LOW, 16'hFFFF);
      write_reg(REG_RATIO_HIGH, 16'hFFFF);
      write_reg(REG_SPREAD_PENALTY, 16'hFFFF);
      write_reg(REG_WINDOW_SIZE, 16'd1);
      send_sample(16'hFFFF);
      send_sample(16'h0000);
      write_reg(REG_WINDOW_SIZE, 16'd0);
      send_sample(16'h1234);
      send_sample(16'hFFFF);
      write_reg(REG_WINDOW_SIZE, 16'd3);
      send_sample(16'hFFFF);
      send_sample(16'h0000);
      send_sample(16'hFFFF);
      send_sample(16'h0000);
      send_sample(16'h0000);
      write_reg(REG_WINDOW_SIZE, 16'd127);
      write_reg(8'hFF, 16'hFFFF);
      write_reg(REG_RATIO_LOW, 16'd0);
      write_reg(REG_RATIO_HIGH, 16'd0);
      write_reg(REG_SPREAD_PENALTY, 16'd0);
      send_sample(16'hAAAA);
      send_sample(16'h5555);
      send_sample(16'hFFFF);

      // Random phases under each idling pattern.
      for (int mode = 0; mode < 5; mode++) begin
         case (mode)
            1: begin send_idle_pct = 78; stall_pct = 0; end
            2: begin send_idle_pct = 0; stall_pct = 78; end
            3: begin send_idle_pct = 19; stall_pct = 19; end
            default: begin send_idle_pct = 0; stall_pct = 0; end
         endcase
         for (int p = 0; p < 5; p++) random_phase($urandom_range(10, 40));
      end
      send_idle_pct = 0;
      stall_pct = 0;
      for (int i = 0; i < 100; i++) send_sample(pick_sample(2));

      // Wait for the last results, then settle.
      req_tvalid <= 1'b0;
      while (board.pending_stats.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (board.errors == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
